FILE: sv/ebp_pkg.sv
`timescale 1ns / 1ps
package ebp_pkg;

   // Default sizes of the block
   localparam int MAX_VERTICES_DEF   = 65536;
   localparam int MAX_PARTITIONS_DEF = 8;
   localparam int COUNT_BITS_DEF     = 24;

   // Fixed field widths
   localparam int ID_W     = 16;
   localparam int WGT_W    = 32;
   localparam int BLK_W    = 3;
   localparam int POS_W    = 24;
   localparam int VC_W     = 17;
   localparam int PC_W     = 4;
   localparam int CSR_IX_W = 2;

   // Register reset values
   localparam logic [VC_W-1:0] VERTEX_COUNT_RST    = 17'd65536;
   localparam logic [PC_W-1:0] PARTITION_COUNT_RST = 4'd8;

   // Register indexes
   localparam logic [CSR_IX_W-1:0] CSR_VERTEX_COUNT    = 2'd0;
   localparam logic [CSR_IX_W-1:0] CSR_PARTITION_COUNT = 2'd1;
   localparam logic [CSR_IX_W-1:0] CSR_WEIGHTED        = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      cmd_type            command;
      logic [ID_W-1:0]    source_vertex;
      logic [ID_W-1:0]    target_vertex;
      logic [ID_W-1:0]    new_label;
      logic [WGT_W-1:0]   weight_bits;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [ID_W-1:0]    new_source;
      logic [ID_W-1:0]    new_target;
      logic [WGT_W-1:0]   weight_out;
      logic [BLK_W-1:0]   row_block;
      logic [BLK_W-1:0]   col_block;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   block_count;
      logic               range_error;
      logic               last;
   } rsp_type;

   // Status handed from the partition setup unit to the main control
   typedef struct packed {
      logic               busy;
      logic               weighted;
      logic [PC_W-1:0]    parts;
   } cfg_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EDGE_OUT,
      ST_SUM_READ,
      ST_SUM_OUT
   } state_type;

   typedef enum logic [1:0] {
      CFG_LOAD,
      CFG_DIV,
      CFG_BOUND,
      CFG_DONE
   } cfg_state_type;

endpackage

FILE: sv/ebp_relabel_mem.sv
`timescale 1ns / 1ps
module ebp_relabel_mem #(
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [ebp_pkg::ID_W-1:0]   wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr_a,
   input  logic [AW-1:0]              rd_addr_b,
   output logic [ebp_pkg::ID_W-1:0]   rd_data_a,
   output logic [ebp_pkg::ID_W-1:0]   rd_data_b
);

   logic [ebp_pkg::ID_W-1:0] mem [DEPTH];
   logic [ebp_pkg::ID_W-1:0] rd_a_ff;
   logic [ebp_pkg::ID_W-1:0] rd_b_ff;

   // Write one label
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read both endpoints, hold otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: sv/ebp_count_mem.sv
`timescale 1ns / 1ps
module ebp_count_mem #(
   parameter int DEPTH      = 64,
   parameter int COUNT_BITS = 24,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_all,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [COUNT_BITS-1:0] rd_data
);

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [COUNT_BITS-1:0] data_ff;
   logic                  hit_ff;

   // Mark written entries, drop all marks on clear
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a cleared entry reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

FILE: sv/ebp_part_cfg.sv
`timescale 1ns / 1ps
module ebp_part_cfg #(
   parameter int MAX_VERTICES   = ebp_pkg::MAX_VERTICES_DEF,
   parameter int MAX_PARTITIONS = ebp_pkg::MAX_PARTITIONS_DEF,
   localparam int VW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ebp_pkg::CSR_IX_W-1:0]      csr_index,
   input  logic [ebp_pkg::VC_W-1:0]          csr_data,
   output ebp_pkg::cfg_status_type           status,
   output logic [VW-1:0]                     eff_vertices,
   output logic [MAX_PARTITIONS-1:0][VW-1:0] bound
);

   localparam int SW = $clog2(VW);
   localparam int KW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

   logic [ebp_pkg::VC_W-1:0] vc_ff;
   logic [ebp_pkg::PC_W-1:0] pc_ff;
   logic                     wt_ff;
   logic [24:0]              v_wide;
   logic [VW-1:0]            v_eff;
   logic [ebp_pkg::PC_W-1:0] p_clamp;
   logic [ebp_pkg::PC_W-1:0] p_eff;

   ebp_pkg::cfg_state_type   cstate_ff;
   ebp_pkg::cfg_state_type   cstate_in;
   logic                     csr_write;
   logic                     do_load;
   logic                     do_div;
   logic                     do_bound;

   logic [VW-1:0]            dvd_ff;
   logic [VW-1:0]            quo_ff;
   logic [4:0]               rem_ff;
   logic [SW-1:0]            step_ff;
   logic [KW-1:0]            k_ff;
   logic [VW-1:0]            acc_ff;
   logic [MAX_PARTITIONS-1:0][VW-1:0] bound_ff;
   logic [4:0]               trial;
   logic [VW-1:0]            next_bound;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= ebp_pkg::VERTEX_COUNT_RST;
         pc_ff <= ebp_pkg::PARTITION_COUNT_RST;
         wt_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            ebp_pkg::CSR_VERTEX_COUNT:    vc_ff <= csr_data;
            ebp_pkg::CSR_PARTITION_COUNT: pc_ff <= csr_data[ebp_pkg::PC_W-1:0];
            ebp_pkg::CSR_WEIGHTED:        wt_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp vertex and partition counts to their working range
   always_comb begin
      if (vc_ff == '0) begin
         v_wide = 25'd1;
      end else if (25'(vc_ff) > 25'(MAX_VERTICES)) begin
         v_wide = 25'(MAX_VERTICES);
      end else begin
         v_wide = 25'(vc_ff);
      end
      v_eff = v_wide[VW-1:0];
      if (pc_ff == '0) begin
         p_clamp = 4'd1;
      end else if (32'(pc_ff) > 32'(MAX_PARTITIONS)) begin
         p_clamp = 4'(MAX_PARTITIONS);
      end else begin
         p_clamp = pc_ff;
      end
      p_eff = (25'(p_clamp) > v_wide) ? v_wide[ebp_pkg::PC_W-1:0] : p_clamp;
   end

   // Next state: restart after reset or any register write
   always_comb begin
      cstate_in = cstate_ff;
      case (cstate_ff)
         ebp_pkg::CFG_LOAD:  cstate_in = ebp_pkg::CFG_DIV;
         ebp_pkg::CFG_DIV: begin
            if (step_ff == SW'(VW - 1)) cstate_in = ebp_pkg::CFG_BOUND;
         end
         ebp_pkg::CFG_BOUND: begin
            if (k_ff == KW'(MAX_PARTITIONS - 1)) cstate_in = ebp_pkg::CFG_DONE;
         end
         ebp_pkg::CFG_DONE:  cstate_in = ebp_pkg::CFG_DONE;
         default:            cstate_in = ebp_pkg::CFG_LOAD;
      endcase
      if (csr_write) cstate_in = ebp_pkg::CFG_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cstate_ff <= ebp_pkg::CFG_LOAD;
      end else begin
         cstate_ff <= cstate_in;
      end
   end

   // Outputs of the sequencer
   always_comb begin
      do_load  = 1'b0;
      do_div   = 1'b0;
      do_bound = 1'b0;
      case (cstate_ff)
         ebp_pkg::CFG_LOAD:  do_load  = 1'b1;
         ebp_pkg::CFG_DIV:   do_div   = 1'b1;
         ebp_pkg::CFG_BOUND: do_bound = 1'b1;
         default: ;
      endcase
   end

   // One quotient bit a cycle, then one partition boundary a cycle
   assign trial      = {rem_ff[3:0], dvd_ff[VW-1]};
   assign next_bound = acc_ff + quo_ff + VW'(4'(k_ff) < rem_ff[3:0]);

   always_ff @(posedge clock) begin
      if (do_load) begin
         dvd_ff  <= v_eff;
         quo_ff  <= '0;
         rem_ff  <= '0;
         step_ff <= '0;
         k_ff    <= '0;
         acc_ff  <= '0;
      end else if (do_div) begin
         dvd_ff  <= dvd_ff << 1;
         step_ff <= step_ff + 1'b1;
         if (trial >= {1'b0, p_eff}) begin
            rem_ff <= trial - {1'b0, p_eff};
            quo_ff <= {quo_ff[VW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[VW-2:0], 1'b0};
         end
      end else if (do_bound) begin
         bound_ff[k_ff] <= next_bound;
         acc_ff         <= next_bound;
         k_ff           <= k_ff + 1'b1;
      end
   end

   assign status.busy     = (cstate_ff != ebp_pkg::CFG_DONE);
   assign status.weighted = wt_ff;
   assign status.parts    = p_eff;
   assign eff_vertices    = v_eff;
   assign bound           = bound_ff;

endmodule

FILE: sv/edge_grid_block_partitioner.sv
`timescale 1ns / 1ps
// Edge grid block partitioner. Load items write the vertex relabel table and
// produce nothing; an edge item passes a two-port relabel table read, a
// partition compare and a counter read-modify-write, waits while the result
// side is full and is then loaded into the result register; the next item is
// taken only after that. An end-of-chunk item emits the clamped partition_count
// squared summaries, each after its own read of the block counter memory, and
// clears the counters as the last summary is loaded. After reset and after
// every register write the block takes no item while it divides vertex_count
// by partition_count and builds the partition boundaries; register writes are
// always taken.
module edge_grid_block_partitioner #(
   parameter int MAX_VERTICES   = ebp_pkg::MAX_VERTICES_DEF,
   parameter int MAX_PARTITIONS = ebp_pkg::MAX_PARTITIONS_DEF,
   parameter int COUNT_BITS     = ebp_pkg::COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ebp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ebp_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ebp_pkg::CSR_IX_W-1:0]  csr_index,
   input  logic [ebp_pkg::VC_W-1:0]      csr_data
);

   localparam int VW       = $clog2(MAX_VERTICES + 1);
   localparam int TD       = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
   localparam int TAW      = (TD > 1) ? $clog2(TD) : 1;
   localparam int CD       = MAX_PARTITIONS * MAX_PARTITIONS;
   localparam int CAW      = (CD > 1) ? $clog2(CD) : 1;
   localparam int BW       = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   ebp_pkg::cfg_status_type           cfg_status;
   logic [VW-1:0]                     v_eff;
   logic [MAX_PARTITIONS-1:0][VW-1:0] bound;

   ebp_pkg::state_type   state_ff;
   ebp_pkg::state_type   state_in;
   ebp_pkg::req_type     req_ff;
   logic                 req_take;
   logic                 out_free;

   logic                 src_ok_ff;
   logic                 dst_ok_ff;
   logic [ebp_pkg::ID_W-1:0] tbl_a;
   logic [ebp_pkg::ID_W-1:0] tbl_b;
   logic [ebp_pkg::ID_W-1:0] ns;
   logic [ebp_pkg::ID_W-1:0] nt;
   logic                 err;
   logic [ebp_pkg::BLK_W-1:0] row;
   logic [ebp_pkg::BLK_W-1:0] col;

   logic [ebp_pkg::ID_W-1:0] ns_ff;
   logic [ebp_pkg::ID_W-1:0] nt_ff;
   logic                 err_ff;
   logic [ebp_pkg::BLK_W-1:0] row_ff;
   logic [ebp_pkg::BLK_W-1:0] col_ff;
   logic [CAW-1:0]       idx_ff;

   logic [BW-1:0]        i_ff;
   logic [BW-1:0]        j_ff;
   logic [COUNT_BITS-1:0] start_ff;
   logic [COUNT_BITS:0]  start_sum;
   logic                 sum_last;

   logic                 tbl_wr;
   logic                 tbl_rd;
   logic                 cnt_rd;
   logic [CAW-1:0]       cnt_rd_addr;
   logic                 cnt_wr;
   logic                 cnt_clear;
   logic [COUNT_BITS-1:0] cnt_q;
   logic                 rsp_load;
   ebp_pkg::rsp_type     rsp_in;
   ebp_pkg::rsp_type     rsp_ff;
   logic                 rsp_valid_ff;

   ebp_part_cfg #(
      .MAX_VERTICES   (MAX_VERTICES),
      .MAX_PARTITIONS (MAX_PARTITIONS)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .status       (cfg_status),
      .eff_vertices (v_eff),
      .bound        (bound)
   );

   ebp_relabel_mem #(.DEPTH(TD)) u_table (
      .clock     (clock),
      .wr_en     (tbl_wr),
      .wr_addr   (req_data.source_vertex[TAW-1:0]),
      .wr_data   (req_data.new_label),
      .rd_en     (tbl_rd),
      .rd_addr_a (req_data.source_vertex[TAW-1:0]),
      .rd_addr_b (req_data.target_vertex[TAW-1:0]),
      .rd_data_a (tbl_a),
      .rd_data_b (tbl_b)
   );

   ebp_count_mem #(.DEPTH(CD), .COUNT_BITS(COUNT_BITS)) u_count (
      .clock     (clock),
      .reset     (reset),
      .clear_all (cnt_clear),
      .wr_en     (cnt_wr),
      .wr_addr   (idx_ff),
      .wr_data   (cnt_q + 1'b1),
      .rd_en     (cnt_rd),
      .rd_addr   (cnt_rd_addr),
      .rd_data   (cnt_q)
   );

   assign req_ready = (state_ff == ebp_pkg::ST_IDLE) && !cfg_status.busy;
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Relabel both endpoints, flag out-of-range vertices and find their partitions
   always_comb begin
      ns  = src_ok_ff ? tbl_a : '0;
      nt  = dst_ok_ff ? tbl_b : '0;
      err = (32'(req_ff.source_vertex) >= 32'(v_eff)) ||
            (32'(req_ff.target_vertex) >= 32'(v_eff)) ||
            (32'(ns) >= 32'(v_eff)) || (32'(nt) >= 32'(v_eff));
      row = '0;
      col = '0;
      for (int k = 0; k < MAX_PARTITIONS - 1; k++) begin
         if ((k + 1) < int'(cfg_status.parts)) begin
            if (32'(ns) >= 32'(bound[k])) row = row + 1'b1;
            if (32'(nt) >= 32'(bound[k])) col = col + 1'b1;
         end
      end
      if (err) begin
         row = '0;
         col = '0;
      end
   end

   assign start_sum = {1'b0, start_ff} + {1'b0, cnt_q};
   assign sum_last  = (32'(i_ff) + 1 == 32'(cfg_status.parts)) &&
                      (32'(j_ff) + 1 == 32'(cfg_status.parts));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ebp_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_data.command)
                  ebp_pkg::CMD_EDGE:  state_in = ebp_pkg::ST_LOOKUP;
                  ebp_pkg::CMD_FLUSH: state_in = ebp_pkg::ST_SUM_READ;
                  default:            state_in = ebp_pkg::ST_IDLE;
               endcase
            end
         end
         ebp_pkg::ST_LOOKUP:   state_in = ebp_pkg::ST_EDGE_OUT;
         ebp_pkg::ST_EDGE_OUT: begin
            if (out_free) state_in = ebp_pkg::ST_IDLE;
         end
         ebp_pkg::ST_SUM_READ: state_in = ebp_pkg::ST_SUM_OUT;
         ebp_pkg::ST_SUM_OUT: begin
            if (out_free) begin
               state_in = sum_last ? ebp_pkg::ST_IDLE : ebp_pkg::ST_SUM_READ;
            end
         end
         default: state_in = ebp_pkg::ST_IDLE;
      endcase
   end

   // Control outputs and the result item
   always_comb begin
      tbl_wr      = 1'b0;
      tbl_rd      = 1'b0;
      cnt_rd      = 1'b0;
      cnt_rd_addr = CAW'(32'(row) * MAX_PARTITIONS + 32'(col));
      cnt_wr      = 1'b0;
      cnt_clear   = 1'b0;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      case (state_ff)
         ebp_pkg::ST_IDLE: begin
            if (req_take && req_data.command == ebp_pkg::CMD_LOAD) begin
               tbl_wr = (32'(req_data.source_vertex) < MAX_VERTICES);
            end
            tbl_rd = req_take && (req_data.command == ebp_pkg::CMD_EDGE);
         end
         ebp_pkg::ST_LOOKUP: begin
            cnt_rd = 1'b1;
         end
         ebp_pkg::ST_EDGE_OUT: begin
            rsp_load           = out_free;
            cnt_wr             = out_free && !err_ff && (cnt_q != COUNT_MAX);
            rsp_in.result_kind = ebp_pkg::KIND_EDGE;
            rsp_in.new_source  = ns_ff;
            rsp_in.new_target  = nt_ff;
            rsp_in.weight_out  = cfg_status.weighted ? req_ff.weight_bits : '0;
            rsp_in.row_block   = row_ff;
            rsp_in.col_block   = col_ff;
            rsp_in.position    = err_ff ? '0 : ebp_pkg::POS_W'(cnt_q);
            rsp_in.range_error = err_ff;
            rsp_in.last        = 1'b1;
         end
         ebp_pkg::ST_SUM_READ: begin
            cnt_rd      = 1'b1;
            cnt_rd_addr = CAW'(32'(i_ff) * MAX_PARTITIONS + 32'(j_ff));
         end
         ebp_pkg::ST_SUM_OUT: begin
            rsp_load           = out_free;
            cnt_clear          = out_free && sum_last;
            rsp_in.result_kind = ebp_pkg::KIND_SUMMARY;
            rsp_in.row_block   = ebp_pkg::BLK_W'(i_ff);
            rsp_in.col_block   = ebp_pkg::BLK_W'(j_ff);
            rsp_in.position    = ebp_pkg::POS_W'(start_ff);
            rsp_in.block_count = ebp_pkg::POS_W'(cnt_q);
            rsp_in.last        = sum_last;
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ebp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff    <= req_data;
         src_ok_ff <= (32'(req_data.source_vertex) < MAX_VERTICES);
         dst_ok_ff <= (32'(req_data.target_vertex) < MAX_VERTICES);
         i_ff      <= '0;
         j_ff      <= '0;
         start_ff  <= '0;
      end
      if (state_ff == ebp_pkg::ST_LOOKUP) begin
         ns_ff  <= ns;
         nt_ff  <= nt;
         err_ff <= err;
         row_ff <= row;
         col_ff <= col;
         idx_ff <= cnt_rd_addr;
      end
      // Advance the summary walk in row-major order
      if (state_ff == ebp_pkg::ST_SUM_OUT && out_free) begin
         start_ff <= start_sum[COUNT_BITS] ? COUNT_MAX : start_sum[COUNT_BITS-1:0];
         if (32'(j_ff) + 1 == 32'(cfg_status.parts)) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // No item is taken while partition setup runs
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg_status.busy |-> !req_ready)
      else $error("item accepted during partition setup");

   // An out-of-range edge carries no block placement
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.range_error |->
         rsp_ff.row_block == '0 && rsp_ff.col_block == '0 && rsp_ff.position == '0)
      else $error("range error with block placement");

   // An edge result is a single closing item with no count
   a_edge_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.result_kind == ebp_pkg::KIND_EDGE |->
         rsp_ff.last && rsp_ff.block_count == '0)
      else $error("edge result malformed");

   // The final summary returns control to idle
   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_in.result_kind == ebp_pkg::KIND_SUMMARY && rsp_in.last |=>
         state_ff == ebp_pkg::ST_IDLE)
      else $error("summary walk did not end");

endmodule
